[sv/rwr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwr_pkg
// Shared types and constants for the reorder window receiver.
// ----------------------------------------------------------------------------
package rwr_pkg;

    localparam int SEQ_BITS = 6;
    localparam int DEPTH    = 1 << SEQ_BITS;
    localparam int WIN_W    = 6;
    localparam int CFG_W    = 6;
    localparam int CMP_W    = (SEQ_BITS > WIN_W) ? SEQ_BITS : WIN_W;

    typedef logic [SEQ_BITS-1:0] t_seq;
    typedef logic [WIN_W-1:0]    t_win;

    // register indexes on the configuration port
    localparam logic CFG_WINDOW_SIZE    = 1'b0;
    localparam logic CFG_START_SEQUENCE = 1'b1;

    // result kinds
    localparam logic KIND_DELIVER = 1'b0;
    localparam logic KIND_DROP    = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ADV,
        ST_TEST
    } t_state;

    typedef enum logic {
        ALU_SUB,
        ALU_INC
    } t_alu_op;

    typedef struct packed {
        t_seq y;
        logic zero;
        logic below;
    } t_alu_res;

endpackage

[sv/reorder_window_receiver_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reorder_window_receiver_top
// Selective-repeat receive window with in-order delivery of sequence numbers.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one sequence number per
//   transfer. Output channel (o_out_valid / i_out_ready) carries one result
//   per transfer: kind (deliver or drop), the number, and a last flag on the
//   final result of each input transfer. A buffered number gives no result.
//   Configuration: write window_size (index 0) or start_sequence (index 1)
//   through i_cfg_we / i_cfg_index / i_cfg_data while the block is idle;
//   start_sequence also empties the window.
// Sequencing:
//   A dropped or buffered number passes the transfer cycle (which issues
//   the presence lookup) and the check state; o_in_ready returns when the
//   check state is left, which a drop delays while the output register is
//   full. A delivery makes one flush step per delivered number: each step
//   uses the shared adder once, then waits for the registered RAM read.
// Reset clears the sequencer, the output register and all presence valid
// bits at once; there is no clearing pass. If the receiver stalls, the
// sequencer holds on its pending result until the output register frees.
// ----------------------------------------------------------------------------
module reorder_window_receiver_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [5:0]                i_seq_number,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_kind,
    output logic [5:0]                o_seq_value,
    output logic                      o_last,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_index,
    input  logic [rwr_pkg::CFG_W-1:0] i_cfg_data
);

    rwr_pkg::t_state r_state, n_state;
    rwr_pkg::t_seq   r_seq, n_seq;       // number under test
    rwr_pkg::t_seq   r_exp, n_exp;       // expected number
    rwr_pkg::t_seq   r_pend, n_pend;     // delivery waiting for its last flag
    rwr_pkg::t_win   r_win, n_win;
    logic [rwr_pkg::DEPTH-1:0] r_vld, n_vld;

    logic            r_out_valid, n_out_valid;
    logic            r_out_kind, n_out_kind;
    rwr_pkg::t_seq   r_out_value, n_out_value;
    logic            r_out_last, n_out_last;

    // presence RAM and shared unit
    logic              ram_we;
    rwr_pkg::t_seq     ram_raddr;
    logic              ram_q;
    rwr_pkg::t_alu_op  alu_op;
    rwr_pkg::t_seq     alu_a;
    rwr_pkg::t_alu_res alu_res;

    logic out_free;
    logic present_seq;
    logic present_exp;

    rwr_ram #(
        .WIDTH (1),
        .DEPTH (rwr_pkg::DEPTH)
    ) u_present (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_seq),
        .i_wdata (1'b1),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    rwr_alu u_alu (
        .i_op     (alu_op),
        .i_a      (alu_a),
        .i_b      (r_exp),
        .i_window (r_win),
        .o_res    (alu_res)
    );

    assign out_free    = !r_out_valid || i_out_ready;
    // an entry whose valid bit is clear reads as not buffered
    assign present_seq = r_vld[r_seq] & ram_q;
    assign present_exp = r_vld[r_exp] & ram_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rwr_pkg::ST_IDLE;
            r_exp       <= '0;
            r_win       <= rwr_pkg::t_win'(8);
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_exp       <= n_exp;
            r_win       <= n_win;
            r_vld       <= n_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seq       <= n_seq;
        r_pend      <= n_pend;
        r_out_kind  <= n_out_kind;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
    end

    always_comb begin
        n_state     = r_state;
        n_seq       = r_seq;
        n_exp       = r_exp;
        n_pend      = r_pend;
        n_win       = r_win;
        n_vld       = r_vld;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_kind  = r_out_kind;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;
        ram_we      = 1'b0;
        ram_raddr   = r_exp;
        alu_op      = rwr_pkg::ALU_SUB;
        alu_a       = r_seq;

        unique case (r_state)
            rwr_pkg::ST_IDLE: begin
                // look up the arriving number during its transfer
                ram_raddr = i_seq_number[rwr_pkg::SEQ_BITS-1:0];
                if (i_in_valid) begin
                    n_seq   = i_seq_number[rwr_pkg::SEQ_BITS-1:0];
                    n_state = rwr_pkg::ST_CHECK;
                end
            end
            rwr_pkg::ST_CHECK: begin
                ram_raddr = r_seq;
                if (alu_res.zero) begin
                    // expected number: hold it until the flush shows its last flag
                    n_pend  = r_seq;
                    n_state = rwr_pkg::ST_ADV;
                end else if (!alu_res.below || present_seq) begin
                    // outside the window or duplicate: drop
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out_kind  = rwr_pkg::KIND_DROP;
                        n_out_value = r_seq;
                        n_out_last  = 1'b1;
                        n_state     = rwr_pkg::ST_IDLE;
                    end
                end else begin
                    ram_we       = 1'b1;
                    n_vld[r_seq] = 1'b1;
                    n_state      = rwr_pkg::ST_IDLE;
                end
            end
            rwr_pkg::ST_ADV: begin
                alu_op    = rwr_pkg::ALU_INC;
                alu_a     = r_exp;
                ram_raddr = alu_res.y;
                n_exp     = alu_res.y;
                n_state   = rwr_pkg::ST_TEST;
            end
            rwr_pkg::ST_TEST: begin
                ram_raddr = r_exp;
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = rwr_pkg::KIND_DELIVER;
                    n_out_value = r_pend;
                    n_out_last  = !present_exp;
                    if (present_exp) begin
                        n_vld[r_exp] = 1'b0;
                        n_pend       = r_exp;
                        n_state      = rwr_pkg::ST_ADV;
                    end else begin
                        n_state = rwr_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = rwr_pkg::ST_IDLE;
        endcase

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                rwr_pkg::CFG_WINDOW_SIZE: begin
                    n_win = rwr_pkg::t_win'(i_cfg_data);
                end
                rwr_pkg::CFG_START_SEQUENCE: begin
                    n_exp = i_cfg_data[rwr_pkg::SEQ_BITS-1:0];
                    n_vld = '0;
                end
                default: n_win = r_win;
            endcase
        end
    end

    assign o_in_ready  = (r_state == rwr_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_kind      = r_out_kind;
    assign o_seq_value = r_out_value;
    assign o_last      = r_out_last;

endmodule

[sv/rwr_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rwr_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/rwr_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwr_alu
// Shared sequence arithmetic: modular offset with window compare, or increment.
// ----------------------------------------------------------------------------
module rwr_alu (
    input  rwr_pkg::t_alu_op i_op,
    input  rwr_pkg::t_seq    i_a,
    input  rwr_pkg::t_seq    i_b,
    input  rwr_pkg::t_win    i_window,
    output rwr_pkg::t_alu_res o_res
);

    rwr_pkg::t_seq                  sum;
    logic [rwr_pkg::CMP_W-1:0]      cmp_y;
    logic [rwr_pkg::CMP_W-1:0]      cmp_w;

    always_comb begin
        unique case (i_op)
            rwr_pkg::ALU_SUB: sum = i_a - i_b;
            rwr_pkg::ALU_INC: sum = i_a + rwr_pkg::t_seq'(1);
            default:          sum = i_a;
        endcase
        cmp_y       = rwr_pkg::CMP_W'(sum);
        cmp_w       = rwr_pkg::CMP_W'(i_window);
        o_res.y     = sum;
        o_res.zero  = (sum == '0);
        o_res.below = (cmp_y < cmp_w);
    end

endmodule

[dv/rwr_window_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwr_window_checker
// Watches the input, output and configuration ports of the reorder window
// receiver, predicts every delivery and drop, and compares each output
// transfer field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module rwr_window_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  logic [5:0]                i_seq_number,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic                      i_kind,
    input  logic [5:0]                i_seq_value,
    input  logic                      i_last,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_index,
    input  logic [rwr_pkg::CFG_W-1:0] i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending,
    output rwr_pkg::t_seq             o_next_seq
);

    localparam rwr_pkg::t_win WINDOW_AT_RESET = 6'd8;
    localparam int            MAX_FLUSH       = rwr_pkg::DEPTH - 1;

    typedef struct packed {
        logic          kind;
        rwr_pkg::t_seq seq_value;
        logic          last;
    } t_window_outcome;

    rwr_pkg::t_win             window_size;
    rwr_pkg::t_seq             next_seq;
    logic [rwr_pkg::DEPTH-1:0] held;
    t_window_outcome           window_outcomes[$];
    int                        fails = 0;

    // Deliver the expected number and everything buffered behind it, drop
    // what falls outside the window or is already held, buffer the rest.
    task automatic advance_window(input rwr_pkg::t_seq seq);
        t_window_outcome outcome;
        rwr_pkg::t_seq   cur;
        rwr_pkg::t_seq   offset;
        int              n;
        bit              more;
        if (seq == next_seq) begin
            cur       = seq;
            held[cur] = 1'b0;
            n         = 1;
            more      = 1'b1;
            while (more) begin
                more              = (n < MAX_FLUSH) && held[rwr_pkg::t_seq'(cur + 1'b1)];
                outcome.kind      = rwr_pkg::KIND_DELIVER;
                outcome.seq_value = cur;
                outcome.last      = !more;
                window_outcomes.push_back(outcome);
                if (more) begin
                    cur       = cur + 1'b1;
                    held[cur] = 1'b0;
                    n++;
                end
            end
            next_seq = cur + 1'b1;
        end else begin
            offset = seq - next_seq;
            if (offset >= window_size || held[seq]) begin
                outcome.kind      = rwr_pkg::KIND_DROP;
                outcome.seq_value = seq;
                outcome.last      = 1'b1;
                window_outcomes.push_back(outcome);
            end else begin
                held[seq] = 1'b1;
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_window_outcome want;
        if (!i_rst_n) begin
            window_size = WINDOW_AT_RESET;
            next_seq    = '0;
            held        = '0;
            window_outcomes.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == rwr_pkg::CFG_WINDOW_SIZE) begin
                    window_size = rwr_pkg::t_win'(i_cfg_data);
                end else begin
                    next_seq = rwr_pkg::t_seq'(i_cfg_data);
                    held     = '0;
                end
            end
            if (i_in_valid && i_in_ready) begin
                advance_window(i_seq_number);
            end
            if (i_out_valid && i_out_ready) begin
                if (window_outcomes.size() == 0) begin
                    $error("unexpected result: kind %0d seq_value %0d last %0d",
                           i_kind, i_seq_value, i_last);
                    fails++;
                end else begin
                    want = window_outcomes.pop_front();
                    if (i_kind !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, i_kind);
                        fails++;
                    end
                    if (i_seq_value !== want.seq_value) begin
                        $error("seq_value: expected %0d, got %0d",
                               want.seq_value, i_seq_value);
                        fails++;
                    end
                    if (i_last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, i_last);
                        fails++;
                    end
                end
            end
        end
        o_pending    <= window_outcomes.size();
        o_next_seq   <= next_seq;
        o_fail_count <= fails;
    end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the reorder window receiver with directed and randomised sequence
// numbers, under several window and start settings, with random gaps on the
// input and random stalls on the output. A checker beside the block predicts
// and compares every result; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

    localparam int RESET_CYCLES  = 11;
    // a buffered number gives no result but keeps the block busy through its
    // check state; let that finish before touching the registers
    localparam int SETTLE_CYCLES = 8;
    // random numbers on top of the directed ones, about a hundred in all
    localparam int RANDOM_ITEMS  = 80;

    logic                      clk        = 1'b0;
    logic                      rst_n      = 1'b0;
    logic                      in_valid   = 1'b0;
    logic                      in_ready;
    rwr_pkg::t_seq             seq_number = '0;
    logic                      out_valid;
    logic                      out_ready  = 1'b0;
    logic                      kind;
    rwr_pkg::t_seq             seq_value;
    logic                      res_last;
    logic                      cfg_we     = 1'b0;
    logic                      cfg_index  = rwr_pkg::CFG_WINDOW_SIZE;
    logic [rwr_pkg::CFG_W-1:0] cfg_data   = '0;

    int                        fail_count;
    int                        pending;
    rwr_pkg::t_seq             next_seq;
    bit                        gaps_on     = 1'b1;
    int unsigned               random_sent = 0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    reorder_window_receiver_top u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_seq_number (seq_number),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_kind       (kind),
        .o_seq_value  (seq_value),
        .o_last       (res_last),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    rwr_window_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_seq_number (seq_number),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_kind       (kind),
        .i_seq_value  (seq_value),
        .i_last       (res_last),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_next_seq   (next_seq)
    );

    // Offer one sequence number. Returns at the edge that accepts the
    // transfer, with valid still high, so a back-to-back number can follow
    // without valid dropping in between.
    task automatic send_seq(input rwr_pkg::t_seq seq);
        int unsigned gap;
        gap = gaps_on ? $urandom_range(0, 3) : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        seq_number <= seq;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Release the input, wait until every predicted result has been
    // collected, then let the block finish any silent buffering.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the window, and the start number too when asked (which also
    // empties the buffer). Hold one more edge so the checker's view of the
    // expected number is current on return.
    task automatic write_config(input rwr_pkg::t_win win, input bit load_start,
                                input rwr_pkg::t_seq start);
        cfg_we    <= 1'b1;
        cfg_index <= rwr_pkg::CFG_WINDOW_SIZE;
        cfg_data  <= win;
        @(posedge clk);
        if (load_start) begin
            cfg_index <= rwr_pkg::CFG_START_SEQUENCE;
            cfg_data  <= start;
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // A well-formed run: up to a window's worth of consecutive numbers from the
    // expected one onwards (one for a zero window), in shuffled order, so the
    // final arrival flushes the lot. Now and then sprinkle in a stray number,
    // or leave one out so that the rest stays buffered.
    task automatic run_burst(input rwr_pkg::t_win win);
        rwr_pkg::t_seq order[rwr_pkg::DEPTH];
        rwr_pkg::t_seq tmp;
        int unsigned   len;
        int unsigned   j;
        int unsigned   skip;
        len = (win == 0) ? 1 : $urandom_range(1, win);
        // keep the total close to the planned number of items
        if (random_sent + len > RANDOM_ITEMS) begin
            len = (random_sent < RANDOM_ITEMS) ? RANDOM_ITEMS - random_sent : 0;
        end
        for (int i = 0; i < len; i++) begin
            order[i] = next_seq + rwr_pkg::t_seq'(i);
        end
        for (int i = len - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        skip = ($urandom_range(0, 4) == 0) ? $urandom_range(0, len - 1) : len;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 7) == 0) begin
                send_seq(rwr_pkg::t_seq'($urandom_range(0, rwr_pkg::DEPTH - 1)));
                random_sent++;
            end
            if (i != skip) begin
                send_seq(order[i]);
                random_sent++;
            end
        end
        wait_drained();
    endtask

    // Output side: draw a stall before each result, then hold ready until
    // the transfer happens.
    initial begin : result_sink
        int unsigned hold;
        forever begin
            hold = gaps_on ? $urandom_range(0, 3) : 0;
            if (hold != 0) begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready)) @(posedge clk);
        end
    end

    initial begin : stimulus
        rwr_pkg::t_win win;
        int            bursts;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: window of eight, expecting zero.
        send_seq(6'd0);     // in order
        send_seq(6'd63);    // just behind: outside the window
        send_seq(6'd2);
        send_seq(6'd3);
        send_seq(6'd2);     // duplicate of a held number
        send_seq(6'd8);     // last slot inside the window
        send_seq(6'd9);     // first slot past the window
        send_seq(6'd1);     // flushes 1, 2 and 3
        send_seq(6'd1);     // already delivered
        wait_drained();

        // Zero window, buffer kept: only the expected number gets through.
        write_config(6'd0, 1'b0, '0);
        send_seq(6'd5);
        send_seq(6'd8);
        send_seq(6'd4);
        wait_drained();

        // Widest window, starting at the top so the buffer wraps round.
        write_config(6'd63, 1'b1, 6'd63);
        send_seq(6'd62);    // one behind: the only number outside
        send_seq(6'd0);
        send_seq(6'd61);
        send_seq(6'd1);
        send_seq(6'd63);    // flushes 63, 0 and 1
        wait_drained();

        // Window of one, alternating bit patterns.
        write_config(6'd1, 1'b1, 6'd42);
        send_seq(6'd21);
        send_seq(6'd43);
        send_seq(6'd42);
        wait_drained();

        // Random phases, each with its own settings and idling style.
        while (random_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 5))
                0:       win = 6'd0;
                1:       win = 6'd1;
                2:       win = 6'd63;
                default: win = rwr_pkg::t_win'($urandom_range(2, 62));
            endcase
            gaps_on = ($urandom_range(0, 3) != 0);
            write_config(win, $urandom_range(0, 3) != 0,
                         rwr_pkg::t_seq'($urandom_range(0, rwr_pkg::DEPTH - 1)));
            bursts = $urandom_range(1, 3);
            repeat (bursts) run_burst(win);
        end
        gaps_on = 1'b1;
        wait_drained();

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin : watchdog
        #1_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

[filelist.f]
sv/rwr_pkg.sv
sv/rwr_ram.sv
sv/rwr_alu.sv
sv/reorder_window_receiver_top.sv
dv/rwr_window_checker.sv
dv/testbench.sv
